FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while in reset.
`define U2L_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked while reset is applied.
`define U2L_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/u2l_pkg.sv
// Package for the UTF-8 to Latin-1 decoder: constants and the result type.
// No dependencies.
`default_nettype none

package u2l_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned ByteW = 8;

  localparam logic [CpW-1:0]   ReplacementCp = 21'h00FFFD;
  localparam logic [CpW-1:0]   SurrLow       = 21'h00D800;
  localparam logic [CpW-1:0]   SurrEnd       = 21'h00E000;
  localparam logic [CpW-1:0]   Latin1Max     = 21'h0000FF;
  localparam logic [ByteW-1:0] QuestionMark  = 8'h3F;

  // One result transaction as it sits in the output or skid register.
  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [ByteW-1:0] latin1_byte;
    logic             has_char;
    logic             end_of_text;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/utf8_to_latin1_decoder_top.sv
// Top level of the UTF-8 to Latin-1 decoder: decode logic, state and output skid.
// Depends on u2l_pkg.
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  in_byte_i, last_byte_i
// out      output     out_valid_o / out_stall_i code_point_o, latin1_byte_o,
//                                              has_char_o, end_of_text_o
//
// One byte per cycle while in_stall_o is low; each result is registered in the
// output register, or in the skid entry while the output is held. Decode is a
// single pass of shallow logic from the input ports and the state registers.
// A two-deep output (register plus skid) keeps input flowing while a result
// waits; in_stall_o rises only once the skid entry is occupied.
// Reset clears the decode state and both valid flags; payload is not reset.
// The final byte of a text always yields one transaction marked end_of_text and
// returns the decode state to its reset value.
module utf8_to_latin1_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      code_point_o,
  output logic [7:0]       latin1_byte_o,
  output logic             has_char_o,
  output logic             end_of_text_o
);

  // Decode state
  logic [1:0]  pending_q, pending_d;
  logic [20:0] partial_q, partial_d;
  logic        skipping_q, skipping_d;

  // Output register and skid entry
  u2l_pkg::result_t out_q, skid_q, res;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;

  logic        in_acc, out_acc, emit;
  logic        is_cont, has;
  logic [20:0] cp;
  logic [20:0] shifted;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign shifted = {partial_q[14:0], in_byte_i[5:0]};

  // Byte decode
  always_comb begin
    pending_d  = pending_q;
    partial_d  = partial_q;
    skipping_d = skipping_q;
    has        = 1'b0;
    cp         = u2l_pkg::ReplacementCp;

    if (skipping_q && is_cont) begin
      // continuation after a stray continuation or bad lead: dropped
    end else if (pending_q != 2'd0) begin
      if (is_cont) begin
        partial_d = shifted;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          has = 1'b1;
          if (shifted >= u2l_pkg::SurrLow && shifted < u2l_pkg::SurrEnd) begin
            cp = u2l_pkg::ReplacementCp;
          end else begin
            cp = shifted;
          end
        end
      end else begin
        // broken sequence: this byte is swallowed
        has       = 1'b1;
        pending_d = 2'd0;
      end
    end else begin
      skipping_d = 1'b0;
      unique casez (in_byte_i)
        8'b0???_????: begin
          has = 1'b1;
          cp  = {13'd0, in_byte_i};
        end
        8'b110?_????: begin
          partial_d = {16'd0, in_byte_i[4:0]};
          pending_d = 2'd1;
        end
        8'b1110_????: begin
          partial_d = {17'd0, in_byte_i[3:0]};
          pending_d = 2'd2;
        end
        8'b1111_0???: begin
          partial_d = {18'd0, in_byte_i[2:0]};
          pending_d = 2'd3;
        end
        default: begin
          // stray continuation or invalid lead
          has        = 1'b1;
          skipping_d = 1'b1;
        end
      endcase
    end

    if (last_byte_i) begin
      // truncated sequence at end of text
      if (!has && pending_d != 2'd0) begin
        has = 1'b1;
        cp  = u2l_pkg::ReplacementCp;
      end
      pending_d  = 2'd0;
      partial_d  = 21'd0;
      skipping_d = 1'b0;
    end

    emit = has || last_byte_i;

    res.code_point  = has ? cp : 21'd0;
    res.latin1_byte = !has ? 8'd0 :
                      (cp > u2l_pkg::Latin1Max) ? u2l_pkg::QuestionMark : cp[7:0];
    res.has_char    = has;
    res.end_of_text = last_byte_i;
  end

  // Output register / skid steering
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_acc) begin
      out_valid_d  = skid_valid_q;
      skid_valid_d = 1'b0;
    end
    if (in_acc && emit) begin
      if (out_valid_q && !out_acc) begin
        skid_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= 2'd0;
      partial_q    <= 21'd0;
      skipping_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pending_q  <= pending_d;
        partial_q  <= partial_d;
        skipping_q <= skipping_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (out_acc && skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc && emit && !(out_valid_q && !out_acc)) begin
      out_q <= res;
    end
    if (in_acc && emit && out_valid_q && !out_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_q.code_point;
  assign latin1_byte_o = out_q.latin1_byte;
  assign has_char_o    = out_q.has_char;
  assign end_of_text_o = out_q.end_of_text;

endmodule

`default_nettype wire

FILE: rtl/core/u2l_checker.sv
// Port-level checker for the UTF-8 to Latin-1 decoder, bound to the top level.
// Depends on u2l_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u2l_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [20:0] code_point_o,
  input wire logic [7:0]  latin1_byte_o,
  input wire logic        has_char_o,
  input wire logic        end_of_text_o
);

  logic latin1_ok, empty_ok, surr_cp;

  assign latin1_ok = (code_point_o > u2l_pkg::Latin1Max) ?
                     (latin1_byte_o == u2l_pkg::QuestionMark) :
                     (latin1_byte_o == code_point_o[7:0]);
  // a result without a character only closes a text, and carries zeros
  assign empty_ok  = end_of_text_o && code_point_o == 21'd0 && latin1_byte_o == 8'd0;
  assign surr_cp   = code_point_o >= u2l_pkg::SurrLow && code_point_o < u2l_pkg::SurrEnd;

  `U2L_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `U2L_ASSERT(a_empty_zero, out_valid_o && !has_char_o |-> empty_ok, "bad empty result")
  `U2L_ASSERT(a_latin1_map, out_valid_o && has_char_o |-> latin1_ok, "bad Latin-1 byte")
  `U2L_ASSERT(a_surrogate, out_valid_o |-> !surr_cp, "surrogate passed through")
  `U2L_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "valid straight after reset")

endmodule

bind utf8_to_latin1_decoder_top u2l_checker u_u2l_checker (.*);

`default_nettype wire
